FILE: hw/rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg: shared types and constants of the chained hash table
// Request, response and job formats, opcode and status codes, divider sizing.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int MAX_BUCKETS_DEF      = 16;
	localparam int SLOTS_PER_BUCKET_DEF = 4;
	localparam int VALUE_BITS_DEF       = 64;

	localparam int KEY_W  = 31;
	localparam int VAL_W  = 64;
	localparam int BCNT_W = 5;

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_GET = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic [BCNT_W-1:0] BCNT_RESET = 5'd16;

	localparam int QUEUE_DEPTH = 2;

	// key remainder is formed four key bits per cycle
	localparam int DIV_DIGIT = 4;
	localparam int DIV_STEPS = (KEY_W + DIV_DIGIT - 1) / DIV_DIGIT;
	localparam int DIV_PAD   = DIV_STEPS * DIV_DIGIT;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] value_out;
	} rsp_t;

	typedef struct packed {
		req_t              req;
		logic [BCNT_W-1:0] bucket;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_chan_t;

endpackage

FILE: hw/rtl/chained_hash_table.sv
// ----------------------------------------------------------------------------
// chained_hash_table: key-value table with separate chaining
// Set, get and delete on 31-bit keys, bucket = key modulo bucket count, clamped to 1..MAX_BUCKETS.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req) is taken at a rising edge with start high and busy low.
//   Each request yields one response: done pulses for one cycle with rsp
//   holding status and value. The receiver cannot stall; it must take done.
//   bucket_count is written over cfg_valid/cfg_ready/cfg_data; the user must
//   write it only while the table is idle, the block does not enforce this; cfg_ready is always high.
// Operation:
//   The front unit forms key mod bucket_count four bits per cycle, so busy
//   stays high after a request transfer until the job enters the queue,
//   longer while the queue is full. The back unit scans the bucket one slot
//   per memory read, then executes and raises done. The front unit can take
//   a new request while the back unit still works on earlier ones; a
//   two-entry queue links the units.
// Reset:
//   bucket_count returns to 16 and every slot is marked invalid by a pass
//   over all MAX_BUCKETS * SLOTS_PER_BUCKET slots (64 by default), during
//   which busy stays high. Configuration writes still land.
// ----------------------------------------------------------------------------
module chained_hash_table #(
	parameter int MAX_BUCKETS      = cht_pkg::MAX_BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = cht_pkg::SLOTS_PER_BUCKET_DEF,
	parameter int VALUE_BITS       = cht_pkg::VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  cht_pkg::req_t              req,
	output logic                       done,
	output cht_pkg::rsp_t              rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cht_pkg::BCNT_W-1:0] cfg_data
);

	logic [cht_pkg::BCNT_W-1:0] bucket_count_q;
	logic                       accept;
	logic                       front_busy;
	logic                       clearing;
	logic                       q_full;
	logic                       q_pop;
	cht_pkg::job_chan_t         q_push;
	cht_pkg::job_chan_t         q_head;

	assign cfg_ready = 1'b1;
	assign busy      = front_busy || clearing;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= cht_pkg::BCNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bucket_count_q <= cfg_data;
		end
	end

	cht_front #(
		.MAX_BUCKETS (MAX_BUCKETS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req          (req),
		.bucket_count (bucket_count_q),
		.full         (q_full),
		.push         (q_push),
		.busy         (front_busy)
	);

	cht_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head)
	);

	cht_back #(
		.MAX_BUCKETS      (MAX_BUCKETS),
		.SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
		.VALUE_BITS       (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.pop      (q_pop),
		.clearing (clearing),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

FILE: hw/rtl/cht_front.sv
// ----------------------------------------------------------------------------
// cht_front: request intake and bucket selection
// Takes a request, reduces its key modulo the bucket count with a radix-16
// restoring remainder unit and hands the classified job to the queue.
// ----------------------------------------------------------------------------
module cht_front #(
	parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  cht_pkg::req_t              req,
	input  logic [cht_pkg::BCNT_W-1:0] bucket_count,
	input  logic                       full,
	output cht_pkg::job_chan_t         push,
	output logic                       busy
);

	localparam int DIV_CAP = (MAX_BUCKETS < 31) ? MAX_BUCKETS : 31;
	localparam int STEP_W  = (cht_pkg::DIV_STEPS > 1) ? $clog2(cht_pkg::DIV_STEPS) : 1;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

	fstate_t                        state_q;
	logic [STEP_W-1:0]              step_q;
	logic [cht_pkg::DIV_PAD-1:0]    dividend_q;
	logic [cht_pkg::BCNT_W-1:0]     rem_q;
	logic [cht_pkg::BCNT_W-1:0]     div_q;
	cht_pkg::req_t                  req_q;

	logic [cht_pkg::BCNT_W-1:0]     divisor;
	logic [cht_pkg::BCNT_W:0]       trial;
	logic [cht_pkg::BCNT_W-1:0]     rem_next;

	// zero counts as one bucket, large counts saturate at the table size
	always_comb begin
		divisor = bucket_count;
		if (bucket_count == '0) begin
			divisor = cht_pkg::BCNT_W'(1);
		end else if (int'(bucket_count) > DIV_CAP) begin
			divisor = cht_pkg::BCNT_W'(DIV_CAP);
		end
	end

	always_comb begin
		rem_next = rem_q;
		trial    = '0;
		for (int i = 0; i < cht_pkg::DIV_DIGIT; i++) begin
			trial = {rem_next, dividend_q[cht_pkg::DIV_PAD-1-i]};
			if (trial >= {1'b0, div_q}) begin
				rem_next = cht_pkg::BCNT_W'(trial - {1'b0, div_q});
			end else begin
				rem_next = trial[cht_pkg::BCNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			step_q     <= '0;
			dividend_q <= '0;
			rem_q      <= '0;
			div_q      <= '0;
			req_q      <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						req_q      <= req;
						dividend_q <= cht_pkg::DIV_PAD'(req.key);
						rem_q      <= '0;
						div_q      <= divisor;
						step_q     <= '0;
						state_q    <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q      <= rem_next;
					dividend_q <= dividend_q << cht_pkg::DIV_DIGIT;
					step_q     <= step_q + 1'b1;
					if (step_q == STEP_W'(cht_pkg::DIV_STEPS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign push.valid      = (state_q == F_PUSH) && !full;
	assign push.job.req    = req_q;
	assign push.job.bucket = rem_q;
	assign busy            = (state_q != F_IDLE);

endmodule

FILE: hw/rtl/cht_queue.sv
// ----------------------------------------------------------------------------
// cht_queue: job queue between front and back
// Small first-in first-out buffer so either side can stall on its own.
// ----------------------------------------------------------------------------
module cht_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  cht_pkg::job_chan_t push,
	output logic               full,
	input  logic               pop,
	output cht_pkg::job_chan_t head
);

	localparam int DEPTH = cht_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cht_pkg::job_t     entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push.valid && !full;
	assign do_pop  = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.job   = entry_q[rd_ptr_q];

endmodule

FILE: hw/rtl/cht_back.sv
// ----------------------------------------------------------------------------
// cht_back: slot store and request execution
// Holds the slot memory, scans the selected bucket one slot per cycle,
// then applies set, get or delete and issues the response strobe.
// ----------------------------------------------------------------------------
module cht_back #(
	parameter int MAX_BUCKETS      = cht_pkg::MAX_BUCKETS_DEF,
	parameter int SLOTS_PER_BUCKET = cht_pkg::SLOTS_PER_BUCKET_DEF,
	parameter int VALUE_BITS       = cht_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cht_pkg::job_chan_t head,
	output logic               pop,
	output logic               clearing,
	output logic               done,
	output cht_pkg::rsp_t      rsp
);

	localparam int TOTAL_SLOTS = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int ADDR_W      = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int SCNT_W      = $clog2(SLOTS_PER_BUCKET + 1);

	typedef struct packed {
		logic                      valid;
		logic [cht_pkg::KEY_W-1:0] key;
		logic [VALUE_BITS-1:0]     value;
	} entry_t;

	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_SCAN, B_EXEC} bstate_t;

	entry_t                   slot_mem [TOTAL_SLOTS];
	entry_t                   rd_data_s2;

	bstate_t                  state_q;
	cht_pkg::job_t            job_q;
	logic [ADDR_W-1:0]        base_q;
	logic [SCNT_W-1:0]        rd_cnt_q;
	logic                     chk_s2;
	logic [ADDR_W-1:0]        chk_addr_s2;
	logic                     hit_q;
	logic [ADDR_W-1:0]        hit_addr_q;
	logic [VALUE_BITS-1:0]    hit_val_q;
	logic                     free_q;
	logic [ADDR_W-1:0]        free_addr_q;
	logic [ADDR_W-1:0]        clr_cnt_q;
	logic                     done_q;
	cht_pkg::rsp_t            rsp_q;

	logic                     rd_en;
	logic [ADDR_W-1:0]        rd_addr;
	logic [ADDR_W-1:0]        base_next;
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	entry_t                   wr_data;
	logic [1:0]               exec_status;
	logic [cht_pkg::VAL_W-1:0] exec_value;

	assign rd_en     = (state_q == B_SCAN) && (rd_cnt_q != SCNT_W'(SLOTS_PER_BUCKET));
	assign rd_addr   = base_q + ADDR_W'(rd_cnt_q);
	assign base_next = ADDR_W'(ADDR_W'(head.job.bucket) * ADDR_W'(SLOTS_PER_BUCKET));
	assign pop       = (state_q == B_IDLE) && head.valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s2 <= slot_mem[rd_addr];
		end
	end

	always_comb begin
		wr_en         = 1'b0;
		wr_addr       = clr_cnt_q;
		wr_data       = '0;
		exec_status   = cht_pkg::ST_OK;
		exec_value    = '0;
		if (state_q == B_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == B_EXEC) begin
			unique case (job_q.req.opcode)
				cht_pkg::OP_SET: begin
					wr_data.valid = 1'b1;
					wr_data.key   = job_q.req.key;
					wr_data.value = VALUE_BITS'(job_q.req.value_in);
					if (hit_q) begin
						wr_en   = 1'b1;
						wr_addr = hit_addr_q;
					end else if (free_q) begin
						wr_en   = 1'b1;
						wr_addr = free_addr_q;
					end else begin
						exec_status = cht_pkg::ST_FULL;
					end
				end
				cht_pkg::OP_GET: begin
					if (hit_q) begin
						exec_value = cht_pkg::VAL_W'(hit_val_q);
					end else begin
						exec_status = cht_pkg::ST_NOT_FOUND;
					end
				end
				cht_pkg::OP_DEL: begin
					// entry written back as all zeros, which drops its valid mark
					if (hit_q) begin
						wr_en   = 1'b1;
						wr_addr = hit_addr_q;
					end else begin
						exec_status = cht_pkg::ST_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			job_q       <= '0;
			base_q      <= '0;
			rd_cnt_q    <= '0;
			chk_s2      <= 1'b0;
			chk_addr_s2 <= '0;
			hit_q       <= 1'b0;
			hit_addr_q  <= '0;
			hit_val_q   <= '0;
			free_q      <= 1'b0;
			free_addr_q <= '0;
			clr_cnt_q   <= '0;
			done_q      <= 1'b0;
			rsp_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ADDR_W'(TOTAL_SLOTS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (head.valid) begin
						job_q    <= head.job;
						base_q   <= base_next;
						rd_cnt_q <= '0;
						chk_s2   <= 1'b0;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						state_q  <= B_SCAN;
					end
				end
				B_SCAN: begin
					chk_s2      <= rd_en;
					chk_addr_s2 <= rd_addr;
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					// first matching key wins, lowest free slot is kept
					if (chk_s2) begin
						if (rd_data_s2.valid) begin
							if (!hit_q && (rd_data_s2.key == job_q.req.key)) begin
								hit_q      <= 1'b1;
								hit_addr_q <= chk_addr_s2;
								hit_val_q  <= rd_data_s2.value;
							end
						end else if (!free_q) begin
							free_q      <= 1'b1;
							free_addr_q <= chk_addr_s2;
						end
					end
					if (chk_s2 && (rd_cnt_q == SCNT_W'(SLOTS_PER_BUCKET))) begin
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					done_q           <= 1'b1;
					rsp_q.status     <= exec_status;
					rsp_q.value_out  <= exec_value;
					state_q          <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign clearing = (state_q == B_CLEAR);
	assign done     = done_q;
	assign rsp      = rsp_q;

endmodule

FILE: hw/rtl/cht_checker.sv
// ----------------------------------------------------------------------------
// cht_checker: port-level checks of the chained hash table
// Watches the request and response ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module cht_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input cht_pkg::rsp_t rsp
);

	// a taken request keeps the intake closed in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after a request transfer");

	// the back unit returns to idle after each response, so the strobe never repeats back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("response strobe on two cycles in a row");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == cht_pkg::ST_OK || rsp.status == cht_pkg::ST_NOT_FOUND ||
			rsp.status == cht_pkg::ST_FULL))
		else $error("undefined response status");

	a_value_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != cht_pkg::ST_OK) |-> (rsp.value_out == '0))
		else $error("nonzero value on a failed request");

endmodule

bind chained_hash_table cht_checker u_cht_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
